// ===== rtl/mmup_pkg.sv =====
// ============================================================================
// mmup_pkg
// Shared widths, register indexes, generator constants and helper functions
// for the multi-mode uniform random generator.
// ============================================================================
`default_nettype none

package mmup_pkg;

    localparam int DRAW_W      = 31;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int TABLE_DEPTH = 55;
    localparam int ADDR_W      = 6;
    localparam int WORD_W      = 30;

    localparam logic [MODE_W-1:0] MODE_PM  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LCG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b1;

    localparam logic [DRAW_W-1:0] PM_MOD   = 31'h7FFF_FFFF;
    localparam logic [14:0]       PM_MUL   = 15'd16807;
    localparam logic [20:0]       LC_MOD   = 21'd1664501;
    localparam logic [10:0]       LC_MUL   = 11'd1229;
    localparam logic [18:0]       LC_ADD   = 19'd351750;
    localparam logic [10:0]       LC_RECIP = 11'd1290;

    localparam logic [WORD_W-1:0] SUB_MOD    = 30'd1000000000;
    localparam logic [WORD_W-1:0] SUB_SEED   = 30'd161803398;
    localparam logic [ADDR_W-1:0] SUB_STRIDE = 6'd21;
    localparam logic [ADDR_W-1:0] SUB_LAG    = 6'd31;
    localparam logic [ADDR_W-1:0] SUB_SPLIT  = 6'd24;
    localparam logic [1:0]        SUB_PASSES = 2'd3;

    function automatic logic [WORD_W-1:0] sub_mod(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] diff;
        diff = {1'b0, a} - {1'b0, b};
        if (diff[WORD_W]) begin
            diff = diff + {1'b0, SUB_MOD};
        end
        return diff[WORD_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] n;
        n = idx + 6'd1;
        if (n > ADDR_W'(TABLE_DEPTH) || n == 6'd0) begin
            n = 6'd1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/multi_mode_uniform_prng.sv =====
// ============================================================================
// multi_mode_uniform_prng
// Integer random draws from a Park-Miller, an LCG or a subtractive lagged
// generator, one draw for each input transfer.
// ============================================================================
//
//  Channel   Direction   Handshake                    Payload
//  -------   ---------   --------------------------   --------------------------
//  input     in          i_in_valid / o_in_stall      i_reseed
//  output    out         o_out_valid / i_out_stall    o_draw_value
//  config    in          i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  Each draw steps through the sequencer: Park-Miller multiplies and then
//  reduces; the LCG runs quotient, remainder and fix steps, an affine step,
//  and quotient, remainder and fix once more; the subtractive generator reads
//  two lag table entries and writes their difference back through the single
//  write port of the lag table memory; the unused mode goes straight to the
//  output. A table build adds 55 seed writes and four passes of 55
//  read-then-write steps. Reset is synchronous and active low; the lag table
//  is not reset. A finished draw waits in the output register while the next
//  input transfer is taken.
`default_nettype none

module multi_mode_uniform_prng (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_stall,
    input  wire logic                                 i_reseed,
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    output      logic [mmup_pkg::DRAW_W-1:0]          o_draw_value,
    input  wire logic                                 i_cfg_valid,
    output      logic                                 o_cfg_ready,
    input  wire logic [mmup_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [mmup_pkg::DRAW_W-1:0]          i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_PM_MUL = 4'd2;
    localparam logic [3:0] S_PM_RED = 4'd3;
    localparam logic [3:0] S_LC_QUO = 4'd4;
    localparam logic [3:0] S_LC_REM = 4'd5;
    localparam logic [3:0] S_LC_FIX = 4'd6;
    localparam logic [3:0] S_LC_AFF = 4'd7;
    localparam logic [3:0] S_BSET   = 4'd8;
    localparam logic [3:0] S_BINIT  = 4'd9;
    localparam logic [3:0] S_BP_RD  = 4'd10;
    localparam logic [3:0] S_BP_WR  = 4'd11;
    localparam logic [3:0] S_SD_RD  = 4'd12;
    localparam logic [3:0] S_SD_WR  = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    localparam int DW = mmup_pkg::DRAW_W;
    localparam int WW = mmup_pkg::WORD_W;
    localparam int AW = mmup_pkg::ADDR_W;

    logic [3:0]                    r_state;
    logic [mmup_pkg::MODE_W-1:0]   r_mode;
    logic [DW-1:0]                 r_start_seed;
    logic [DW-1:0]                 r_seed;
    logic                          r_ready;
    logic                          r_pending;
    logic [AW-1:0]                 r_ri;
    logic [AW-1:0]                 r_li;
    logic                          r_out_valid;
    logic [DW-1:0]                 r_out_data;

    logic [45:0]                   r_prod;
    logic [DW-1:0]                 r_work;
    logic [10:0]                   r_quo;
    logic                          r_lc_pass;
    logic [WW-1:0]                 r_prev;
    logic [WW-1:0]                 r_cur;
    logic [AW-1:0]                 r_pos;
    logic [AW-1:0]                 r_cnt;
    logic [1:0]                    r_pass;
    logic [DW-1:0]                 r_res;

    logic [WW-1:0]                 r_lag_table [0:mmup_pkg::TABLE_DEPTH];
    logic [WW-1:0]                 r_rd_a;
    logic [WW-1:0]                 r_rd_b;

    logic                          in_xfer;
    logic [AW-1:0]                 n_ri;
    logic [AW-1:0]                 n_li;
    logic [WW-1:0]                 n_clamp;
    logic [WW-1:0]                 n_prev0;
    logic [DW:0]                   n_pm_sum;
    logic [DW-1:0]                 n_pm_val;
    logic [41:0]                   n_quo_prod;
    logic [31:0]                   n_rem_prod;
    logic [31:0]                   n_rem;
    logic [DW-1:0]                 n_fix;
    logic [DW-1:0]                 n_aff;
    logic [AW:0]                   n_pos_sum;
    logic [AW-1:0]                 n_pos;
    logic [AW-1:0]                 n_lag_addr;
    logic [WW-1:0]                 n_diff;
    logic [WW-1:0]                 n_cur;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [WW-1:0]                 wr_data;
    logic [AW-1:0]                 rd_addr_a;
    logic [AW-1:0]                 rd_addr_b;

    assign o_in_stall   = (r_state != S_IDLE) || !i_rst_n;
    assign o_cfg_ready  = i_rst_n;
    assign o_out_valid  = r_out_valid;
    assign o_draw_value = r_out_data;
    assign in_xfer      = i_in_valid && !o_in_stall;

    always_comb begin
        n_ri = mmup_pkg::next_index(r_ri);
        n_li = mmup_pkg::next_index(r_li);

        n_clamp = (r_seed > DW'(mmup_pkg::SUB_SEED)) ? mmup_pkg::SUB_SEED : r_seed[WW-1:0];
        n_prev0 = mmup_pkg::SUB_SEED - n_clamp;

        n_pm_sum = {17'd0, r_prod[45:31]} + {1'b0, r_prod[30:0]};
        n_pm_val = (n_pm_sum >= {1'b0, mmup_pkg::PM_MOD})
                 ? DW'(n_pm_sum - {1'b0, mmup_pkg::PM_MOD}) : n_pm_sum[DW-1:0];

        n_quo_prod = 42'(r_work) * 42'(mmup_pkg::LC_RECIP);
        n_rem_prod = 32'(r_quo) * 32'(mmup_pkg::LC_MOD);
        n_rem      = 32'(r_work) - n_rem_prod;
        n_fix      = (r_work >= DW'(mmup_pkg::LC_MOD))
                   ? r_work - DW'(mmup_pkg::LC_MOD) : r_work;
        n_aff      = DW'(r_work[20:0]) * DW'(mmup_pkg::LC_MUL) + DW'(mmup_pkg::LC_ADD);

        n_pos_sum = {1'b0, r_pos} + {1'b0, mmup_pkg::SUB_STRIDE};
        n_pos     = (n_pos_sum >= (AW+1)'(mmup_pkg::TABLE_DEPTH))
                  ? AW'(n_pos_sum - (AW+1)'(mmup_pkg::TABLE_DEPTH)) : n_pos_sum[AW-1:0];
        n_lag_addr = (r_cnt <= mmup_pkg::SUB_SPLIT)
                   ? r_cnt + mmup_pkg::SUB_LAG : r_cnt - mmup_pkg::SUB_SPLIT;

        n_diff = mmup_pkg::sub_mod(r_rd_a, r_rd_b);
        n_cur  = mmup_pkg::sub_mod(r_prev, r_cur);
    end

    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = r_cnt;
        wr_data   = n_diff;
        rd_addr_a = r_cnt;
        rd_addr_b = n_lag_addr;
        case (r_state)
            S_BSET: begin
                wr_en   = 1'b1;
                wr_addr = AW'(mmup_pkg::TABLE_DEPTH);
                wr_data = n_prev0;
            end
            S_BINIT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos;
                wr_data = r_cur;
            end
            S_BP_WR: begin
                wr_en = 1'b1;
            end
            S_SD_RD: begin
                rd_addr_a = n_ri;
                rd_addr_b = n_li;
            end
            S_SD_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_ri;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_lag_table[wr_addr] <= wr_data;
        end
        r_rd_a <= r_lag_table[rd_addr_a];
        r_rd_b <= r_lag_table[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= mmup_pkg::MODE_PM;
            r_start_seed <= DW'(1);
            r_seed       <= '0;
            r_ready      <= 1'b0;
            r_pending    <= 1'b0;
            r_ri         <= '0;
            r_li         <= mmup_pkg::SUB_LAG;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mmup_pkg::CFG_MODE: r_mode       <= i_cfg_data[mmup_pkg::MODE_W-1:0];
                    mmup_pkg::CFG_SEED: r_start_seed <= i_cfg_data;
                    default:            r_mode       <= r_mode;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_reseed) begin
                            r_seed    <= r_start_seed;
                            r_pending <= 1'b1;
                        end
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (r_mode)
                        mmup_pkg::MODE_PM: begin
                            r_state <= S_PM_MUL;
                        end
                        mmup_pkg::MODE_LCG: begin
                            r_work    <= r_seed;
                            r_lc_pass <= 1'b0;
                            r_state   <= S_LC_QUO;
                        end
                        mmup_pkg::MODE_SUB: begin
                            r_state <= (!r_ready || r_pending) ? S_BSET : S_SD_RD;
                        end
                        default: begin
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_PM_MUL: begin
                    r_prod  <= 46'(r_seed) * 46'(mmup_pkg::PM_MUL);
                    r_state <= S_PM_RED;
                end
                S_PM_RED: begin
                    r_seed  <= n_pm_val;
                    r_res   <= n_pm_val;
                    r_state <= S_OUT;
                end
                S_LC_QUO: begin
                    r_quo   <= n_quo_prod[41:31];
                    r_state <= S_LC_REM;
                end
                S_LC_REM: begin
                    r_work  <= n_rem[DW-1:0];
                    r_state <= S_LC_FIX;
                end
                S_LC_FIX: begin
                    if (!r_lc_pass) begin
                        r_work  <= n_fix;
                        r_state <= S_LC_AFF;
                    end else begin
                        r_seed  <= n_fix;
                        r_res   <= n_fix;
                        r_state <= S_OUT;
                    end
                end
                S_LC_AFF: begin
                    r_work    <= n_aff;
                    r_lc_pass <= 1'b1;
                    r_state   <= S_LC_QUO;
                end
                S_BSET: begin
                    r_prev  <= n_prev0;
                    r_cur   <= WW'(1);
                    r_pos   <= mmup_pkg::SUB_STRIDE;
                    r_cnt   <= AW'(1);
                    r_state <= S_BINIT;
                end
                S_BINIT: begin
                    r_cur  <= n_cur;
                    r_prev <= r_cur;
                    r_pos  <= n_pos;
                    if (r_cnt == AW'(mmup_pkg::TABLE_DEPTH - 1)) begin
                        r_cnt   <= AW'(1);
                        r_pass  <= 2'd0;
                        r_state <= S_BP_RD;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_BP_RD: begin
                    r_state <= S_BP_WR;
                end
                S_BP_WR: begin
                    r_state <= S_BP_RD;
                    if (r_cnt == AW'(mmup_pkg::TABLE_DEPTH)) begin
                        r_cnt <= AW'(1);
                        if (r_pass == mmup_pkg::SUB_PASSES) begin
                            r_seed    <= DW'(1);
                            r_ready   <= 1'b1;
                            r_pending <= 1'b0;
                            r_ri      <= '0;
                            r_li      <= mmup_pkg::SUB_LAG;
                            r_state   <= S_SD_RD;
                        end else begin
                            r_pass <= r_pass + 2'd1;
                        end
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_SD_RD: begin
                    r_ri    <= n_ri;
                    r_li    <= n_li;
                    r_state <= S_SD_WR;
                end
                S_SD_WR: begin
                    r_res   <= {1'b0, n_diff};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mmup_checker.sv =====
// ============================================================================
// mmup_checker
// Port-level checks of the multi-mode uniform random generator over time.
// ============================================================================
`default_nettype none

module mmup_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_stall,
    input wire logic                               i_reseed,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_stall,
    input wire logic [mmup_pkg::DRAW_W-1:0]        o_draw_value,
    input wire logic                               i_cfg_valid,
    input wire logic                               o_cfg_ready,
    input wire logic [mmup_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input wire logic [mmup_pkg::DRAW_W-1:0]        i_cfg_data
);

    logic unused_ok;
    assign unused_ok = i_reseed ^ i_cfg_valid ^ o_cfg_ready ^ (^i_cfg_index) ^ (^i_cfg_data);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_draw_value))
        else $error("Stalled draw changed or was dropped.");

    a_draw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_draw_value != mmup_pkg::PM_MOD)
        else $error("Draw equals the Park-Miller modulus.");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall && !$rose(o_out_valid))
        else $error("Input taken again or draw shown one cycle after a transfer.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

endmodule

bind multi_mode_uniform_prng mmup_checker u_mmup_checker (.*);

`default_nettype wire
